// ----- rtl/core/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value table: request and status
// codes, sequencer states, stream field layout and parameter defaults.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // parameter defaults
  localparam int ENTRIES_DEF    = 256;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;

  // fixed field widths on the stream ports
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // input item layout, lowest bits first
  localparam int IN_FUNC_LSB  = 0;
  localparam int IN_KEY_LSB   = IN_FUNC_LSB + FUNC_W;
  localparam int IN_VALUE_LSB = IN_KEY_LSB + KEY_W;
  localparam int IN_USED_W    = IN_VALUE_LSB + VALUE_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // result item layout, lowest bits first
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_VALUE_LSB  = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_COUNT_LSB  = OUT_VALUE_LSB + VALUE_W;
  localparam int OUT_USED_W     = OUT_COUNT_LSB + COUNT_W;
  localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_USED_W;

  // request kinds; the fourth code is unused
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET = 2'd0,
    FUNC_GET = 2'd1,
    FUNC_DEL = 2'd2
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_GETRD,
    ST_RESP
  } state_t;

endpackage

// ----- rtl/core/kvt_ram.sv -----
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-clock RAM, one write port and one read port, with the read
// data registered.
// ----------------------------------------------------------------------------
module kvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/key_value_table.sv -----
// ----------------------------------------------------------------------------
// key_value_table
// Fixed-size key/value table serving set, get and delete requests. Keys with
// their valid flag sit in one RAM, values in another; every request is served
// by a linear scan of the key RAM followed by one read-modify-write step.
// ----------------------------------------------------------------------------
//
//  channel  direction  ports                      payload
//  s_axis   in         s_tvalid s_tready s_tdata  func, key, value
//  m_axis   out        m_tvalid m_tready m_tdata  status, value_out, entry_count
//
//  The scan reads one key RAM entry per cycle, set by the single key RAM read
//  port; a get that hits adds an ST_GETRD step to read the value RAM.
//  After reset a clearing pass zeroes the valid flags of every entry;
//  s_tready stays low during it.
//  One item is in work at a time; a finished result waits in the output
//  register, and the next item is accepted while it waits.
//  A stalled result holds the sequencer in its last step until the output
//  register is free.
//
module key_value_table
  import kvt_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // func[1:0], key[65:2], value[129:66], zero fill [135:130]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // status[1:0], value_out[65:2], entry_count[74:66], zero fill [79:75]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX  = AW'(ENTRIES - 1);
  localparam logic [AW:0]   SCAN_END  = (AW + 1)'(ENTRIES);

  state_t state, state_next;

  // request held for the whole operation
  func_t                 req_func;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  // scan bookkeeping
  logic [AW:0]   issue_cnt;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;
  logic          hit_found;
  logic [AW-1:0] hit_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic [AW-1:0] clr_cnt;

  // result being built
  logic [CW-1:0]         count;
  status_t               res_status;
  logic [VALUE_BITS-1:0] res_value;

  // ram ports
  logic                  key_we;
  logic [AW-1:0]         key_waddr;
  logic [KEY_BITS:0]     key_wdata;
  logic [AW-1:0]         key_raddr;
  logic [KEY_BITS:0]     key_rdata;
  logic                  val_we;
  logic [AW-1:0]         val_waddr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [AW-1:0]         val_raddr;
  logic [VALUE_BITS-1:0] val_rdata;

  logic in_take;
  logic out_load;
  logic entry_valid;
  logic [VALUE_W+VALUE_BITS-1:0] value_wide;
  logic [COUNT_W+CW-1:0]         count_wide;

  assign in_take     = s_tvalid && s_tready;
  assign out_load    = (state == ST_RESP) && (!m_tvalid || m_tready);
  assign entry_valid = key_rdata[KEY_BITS];

  // key ram: valid flag in the top bit
  kvt_ram #(
    .WIDTH (KEY_BITS + 1),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // value ram
  kvt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_pend && rd_idx == LAST_IDX) state_next = ST_ACT;
      end
      ST_ACT: begin
        if (req_func == FUNC_GET && hit_found) state_next = ST_GETRD;
        else state_next = ST_RESP;
      end
      ST_GETRD: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // handshake and ram controls
  always_comb begin
    s_tready  = 1'b0;
    key_we    = 1'b0;
    key_waddr = clr_cnt;
    key_wdata = '0;
    key_raddr = issue_cnt[AW-1:0];
    val_we    = 1'b0;
    val_waddr = hit_idx;
    val_wdata = req_value;
    val_raddr = hit_idx;
    unique case (state)
      ST_CLEAR: begin
        key_we = 1'b1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_ACT: begin
        case (req_func)
          FUNC_SET: begin
            if (hit_found) begin
              val_we = 1'b1;
            end else if (free_found) begin
              key_we    = 1'b1;
              key_waddr = free_idx;
              key_wdata = {1'b1, req_key};
              val_we    = 1'b1;
              val_waddr = free_idx;
            end
          end
          FUNC_DEL: begin
            if (hit_found) begin
              key_we    = 1'b1;
              key_waddr = hit_idx;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN, ST_GETRD, ST_RESP: ;
      default: ;
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_func  <= func_t'(s_tdata[IN_FUNC_LSB +: FUNC_W]);
      req_key   <= s_tdata[IN_KEY_LSB +: KEY_BITS];
      req_value <= s_tdata[IN_VALUE_LSB +: VALUE_BITS];
    end
  end

  // scan: issue one read per cycle, check the entry in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt  <= '0;
      rd_pend    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (in_take) begin
      issue_cnt  <= '0;
      rd_pend    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      rd_pend <= (issue_cnt != SCAN_END);
      if (issue_cnt != SCAN_END) begin
        issue_cnt <= issue_cnt + (AW + 1)'(1);
      end
      if (rd_pend) begin
        if (entry_valid) begin
          if (!hit_found && key_rdata[KEY_BITS-1:0] == req_key) begin
            hit_found <= 1'b1;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  // scan indices
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      rd_idx <= issue_cnt[AW-1:0];
      if (rd_pend) begin
        if (entry_valid) begin
          if (!hit_found && key_rdata[KEY_BITS-1:0] == req_key) begin
            hit_idx <= rd_idx;
          end
        end else if (!free_found) begin
          free_idx <= rd_idx;
        end
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == ST_ACT) begin
      if (req_func == FUNC_SET && !hit_found && free_found) begin
        count <= count + CW'(1);
      end else if (req_func == FUNC_DEL && hit_found && count != '0) begin
        count <= count - CW'(1);
      end
    end
  end

  // result status and value
  always_ff @(posedge clk) begin
    if (state == ST_ACT) begin
      res_value <= '0;
      case (req_func)
        FUNC_SET: res_status <= (hit_found || free_found) ? STATUS_OK : STATUS_FULL;
        FUNC_GET, FUNC_DEL: res_status <= hit_found ? STATUS_OK : STATUS_MISSING;
        default: res_status <= STATUS_MISSING;
      endcase
    end else if (state == ST_GETRD) begin
      res_value <= val_rdata;
    end
  end

  // field widening to the port widths
  assign value_wide = {{VALUE_W{1'b0}}, res_value};
  assign count_wide = {{COUNT_W{1'b0}}, count};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, count_wide[COUNT_W-1:0],
                  value_wide[VALUE_W-1:0], res_status};
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready)
    else $error("item accepted during clearing pass");

  a_set_hit_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACT && req_func == FUNC_SET && hit_found |=> count == $past(count))
    else $error("overwrite changed entry count");

  a_scan_complete: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && state_next == ST_ACT |-> issue_cnt == SCAN_END)
    else $error("scan ended before all entries were read");

endmodule
